// ----- rtl/hds_pkg.sv -----
// Package for the 3D heat diffusion stencil unit.
// Shared types, command and register codes, tap codes and neighbor helpers.
// No dependencies.
package hds_pkg;

    localparam int COORD_W  = 5;
    localparam int COEF_W   = 15;
    localparam int MCOEF_W  = 19;     // signed center coefficient, covers 1 - 6*max
    localparam int ONE_Q15  = 32768;
    localparam int FRAC_SH  = 15;
    localparam int CFG_IDX_W = 3;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LAST_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Z = 3'd5;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COEF_W-1:0]  coef_t;

    typedef enum logic [2:0] {
        TAP_CENTER,
        TAP_X_LO,
        TAP_X_HI,
        TAP_Y_LO,
        TAP_Y_HI,
        TAP_Z_LO,
        TAP_Z_HI
    } tap_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } top_state_t;

    typedef struct packed {
        logic     valid;
        logic     write;
        tap_sel_t tap;
    } tap_info_t;

    typedef struct packed {
        coord_t lx;
        coord_t ly;
        coord_t lz;
    } grid_bounds_t;

    typedef struct packed {
        coef_t cx;
        coef_t cy;
        coef_t cz;
    } coef_set_t;

    // mirror boundary: at a face the inward neighbor stands in for the missing one
    function automatic coord_t lower_nb(input coord_t p, input coord_t last);
        coord_t r;
        if (p != '0)
            r = p - 1'b1;
        else if (p < last)
            r = p + 1'b1;
        else
            r = p;
        return r;
    endfunction

    function automatic coord_t upper_nb(input coord_t p, input coord_t last);
        coord_t r;
        if (p < last)
            r = p + 1'b1;
        else if (p != '0)
            r = p - 1'b1;
        else
            r = p;
        return r;
    endfunction

endpackage

// ----- rtl/heat_diffusion_stencil_3d_unit.sv -----
// Top level of the 3D heat diffusion stencil unit (seven-point, mirror faces).
// Depends on hds_pkg, hds_ram, hds_seq, hds_mac.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: pos_x,pos_y,pos_z,temp_in
//           |     |                              | tuser: cmd
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: temp_new, tuser: coord_error
//  cfg      | in  | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// One item at a time. Compute: the address stages issue seven reads through the single
// port of the grid store, then the multiply, accumulate and round stages fill the
// output register. Write: one store write. An out-of-range item skips the grid store.
// A waiting result does not block the next transfer; the next result waits for the
// output register. No clearing pass after reset.
module heat_diffusion_stencil_3d_unit
    import hds_pkg::*;
#(
    parameter int MAX_POINTS_X = 32,
    parameter int MAX_POINTS_Y = 32,
    parameter int MAX_POINTS_Z = 32,
    parameter int VALUE_BITS   = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,   // pos_x, pos_y, pos_z, temp_in, pad
    input  logic [0:0]           s_axis_tuser,   // cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // temp_new
    output logic [0:0]           m_axis_tuser,   // coord_error
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    localparam int DEPTH = MAX_POINTS_X * MAX_POINTS_Y * MAX_POINTS_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

    coord_t       last_x_reg, last_y_reg, last_z_reg;
    coef_set_t    coef_reg;
    grid_bounds_t bounds;
    top_state_t   state_reg, state_next;

    logic                  in_accept, in_bad, seq_start;
    coord_t                in_x, in_y, in_z;
    logic signed [31:0]    in_temp;
    logic signed [63:0]    tin64, tin_sat;
    logic                  item_cmd_reg, item_err_reg;
    coord_t                item_x_reg, item_y_reg, item_z_reg;
    logic [VALUE_BITS-1:0] item_wdata_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [VALUE_BITS-1:0] ram_rdata;
    tap_info_t             tap_c;
    logic                  mac_done;
    logic [31:0]           mac_temp;

    logic                  out_load;
    logic                  out_valid_reg, out_err_reg;
    logic [31:0]           out_temp_reg;

    function automatic coord_t eff_last(input coord_t last, input int maxpts);
        coord_t r;
        if (32'(last) < maxpts - 1)
            r = last;
        else
            r = COORD_W'(maxpts - 1);
        return r;
    endfunction

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= 5'd31;
            last_y_reg <= 5'd31;
            last_z_reg <= 5'd31;
            coef_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LAST_X: last_x_reg  <= cfg_data[COORD_W-1:0];
                CFG_LAST_Y: last_y_reg  <= cfg_data[COORD_W-1:0];
                CFG_LAST_Z: last_z_reg  <= cfg_data[COORD_W-1:0];
                CFG_COEF_X: coef_reg.cx <= cfg_data;
                CFG_COEF_Y: coef_reg.cy <= cfg_data;
                CFG_COEF_Z: coef_reg.cz <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign bounds.lx = eff_last(last_x_reg, MAX_POINTS_X);
    assign bounds.ly = eff_last(last_y_reg, MAX_POINTS_Y);
    assign bounds.lz = eff_last(last_z_reg, MAX_POINTS_Z);

    // input item
    assign in_x    = s_axis_tdata[4:0];
    assign in_y    = s_axis_tdata[9:5];
    assign in_z    = s_axis_tdata[14:10];
    assign in_temp = $signed(s_axis_tdata[46:15]);
    assign in_bad  = (in_x > bounds.lx) || (in_y > bounds.ly) || (in_z > bounds.lz);
    assign in_accept = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        tin64 = 64'(in_temp);
        if (tin64 > VMAX)
            tin_sat = VMAX;
        else if (tin64 < VMIN)
            tin_sat = VMIN;
        else
            tin_sat = tin64;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_cmd_reg   <= s_axis_tuser[0];
            item_err_reg   <= in_bad;
            item_x_reg     <= in_x;
            item_y_reg     <= in_y;
            item_z_reg     <= in_z;
            item_wdata_reg <= VALUE_BITS'(tin_sat);
        end
    end

    // control
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        seq_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (in_bad)
                        state_next = ST_HOLD;
                    else
                    begin
                        seq_start  = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (tap_c.valid && tap_c.write)
                    state_next = ST_IDLE;
                else if (mac_done)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    hds_seq #(
        .MAX_POINTS_X(MAX_POINTS_X),
        .MAX_POINTS_Y(MAX_POINTS_Y),
        .MAX_POINTS_Z(MAX_POINTS_Z)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (seq_start),
        .write_mode(item_cmd_reg == CMD_WRITE),
        .pos_x     (item_x_reg),
        .pos_y     (item_y_reg),
        .pos_z     (item_z_reg),
        .bounds    (bounds),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .tap_out   (tap_c)
    );

    hds_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(DEPTH)
    ) u_grid (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(item_wdata_reg),
        .rdata(ram_rdata)
    );

    hds_mac #(
        .VALUE_BITS(VALUE_BITS)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .tap     (tap_c),
        .rd_data ($signed(ram_rdata)),
        .coefs   (coef_reg),
        .done    (mac_done),
        .temp_new(mac_temp)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_temp_reg <= item_err_reg ? '0 : mac_temp;
            out_err_reg  <= item_err_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_temp_reg;
    assign m_axis_tuser[0] = out_err_reg;

    // checks
    a_tap_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tap_c.valid |-> state_reg == ST_RUN)
        else $error("stencil tap outside of a running item");

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == ST_RUN)
        else $error("accumulator finished outside of a running item");

    a_bad_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_bad) |=> state_reg == ST_HOLD)
        else $error("out-of-range item did not go to result hold");

    a_write_only_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (item_cmd_reg == CMD_WRITE && state_reg == ST_RUN))
        else $error("grid store written outside of a write item");

endmodule

// ----- rtl/hds_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module hds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/hds_seq.sv -----
// Tap sequencer and address pipeline for the grid store.
// Issues one write or seven stencil reads; depends on hds_pkg.
module hds_seq
    import hds_pkg::*;
#(
    parameter int MAX_POINTS_X = 32,
    parameter int MAX_POINTS_Y = 32,
    parameter int MAX_POINTS_Z = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  write_mode,
    input  coord_t                pos_x,
    input  coord_t                pos_y,
    input  coord_t                pos_z,
    input  grid_bounds_t          bounds,
    output logic                  ram_we,
    output logic [$clog2(MAX_POINTS_X * MAX_POINTS_Y * MAX_POINTS_Z)-1:0] ram_addr,
    output tap_info_t             tap_out
);

    localparam int AW  = $clog2(MAX_POINTS_X * MAX_POINTS_Y * MAX_POINTS_Z);
    localparam int ZYW = $clog2(MAX_POINTS_Y * MAX_POINTS_Z);

    logic            active_reg, active_next;
    logic [2:0]      cnt_reg, cnt_next;
    tap_info_t       a_info_reg, a_info_next;
    coord_t          a_x_reg;
    logic [ZYW-1:0]  a_zy_reg, a_zy_next;
    tap_info_t       b_info_reg;
    logic [AW-1:0]   b_addr_reg, b_addr_next;
    tap_info_t       c_info_reg;
    coord_t          nx, ny, nz;

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
        end
        else if (active_reg)
        begin
            if (write_mode || tap_sel_t'(cnt_reg) == TAP_Z_HI)
                active_next = 1'b0;
            else
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        nx = pos_x;
        ny = pos_y;
        nz = pos_z;
        case (tap_sel_t'(cnt_reg))
            TAP_X_LO: nx = lower_nb(pos_x, bounds.lx);
            TAP_X_HI: nx = upper_nb(pos_x, bounds.lx);
            TAP_Y_LO: ny = lower_nb(pos_y, bounds.ly);
            TAP_Y_HI: ny = upper_nb(pos_y, bounds.ly);
            TAP_Z_LO: nz = lower_nb(pos_z, bounds.lz);
            TAP_Z_HI: nz = upper_nb(pos_z, bounds.lz);
            default:  nx = pos_x;
        endcase
        a_info_next.valid = active_reg;
        a_info_next.write = write_mode;
        a_info_next.tap   = tap_sel_t'(cnt_reg);
        a_zy_next   = ZYW'(ZYW'(nz) * ZYW'(MAX_POINTS_Y) + ZYW'(ny));
        b_addr_next = AW'(AW'(a_zy_reg) * AW'(MAX_POINTS_X) + AW'(a_x_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            a_info_reg <= '0;
            b_info_reg <= '0;
            c_info_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            a_info_reg <= a_info_next;
            b_info_reg <= a_info_reg;
            c_info_reg <= b_info_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_x_reg    <= nx;
        a_zy_reg   <= a_zy_next;
        b_addr_reg <= b_addr_next;
    end

    assign ram_addr = b_addr_reg;
    assign ram_we   = b_info_reg.valid & b_info_reg.write;
    // aligned with the registered read data of the store
    assign tap_out  = c_info_reg;

endmodule

// ----- rtl/hds_mac.sv -----
// Multiply-accumulate, rounding and saturation for the stencil taps.
// Depends on hds_pkg.
module hds_mac
    import hds_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tap_info_t                    tap,
    input  logic signed [VALUE_BITS-1:0] rd_data,
    input  coef_set_t                    coefs,
    output logic                         done,
    output logic [31:0]                  temp_new
);

    localparam int HW    = VALUE_BITS - 15;       // high part, value >>> 16
    localparam int LPW   = MCOEF_W + 17;
    localparam int HPW   = MCOEF_W + HW;
    localparam int ALW   = LPW + 3;               // seven terms
    localparam int AHW   = HPW + 3;
    localparam int SUM_W = VALUE_BITS + 24;
    localparam int OUT_BITS = VALUE_BITS < 32 ? VALUE_BITS : 32;
    localparam logic signed [SUM_W-1:0] OMAX =
        SUM_W'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] OMIN = -OMAX - 1;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(ONE_Q15 / 2);

    logic signed [MCOEF_W-1:0] coef_c_reg, coef_c_next, coef_sel;
    logic [16:0]               csum;
    logic signed [16:0]        lo_s;
    logic signed [HW-1:0]      hi_s;
    logic                      m_valid_reg, m_first_reg, m_last_reg;
    logic signed [LPW-1:0]     prod_lo_reg, prod_lo_next;
    logic signed [HPW-1:0]     prod_hi_reg, prod_hi_next;
    logic signed [ALW-1:0]     acc_lo_reg, acc_lo_next;
    logic signed [AHW-1:0]     acc_hi_reg, acc_hi_next;
    logic                      fin_reg, f1_reg, done_reg;
    logic signed [SUM_W-1:0]   sum_reg, sum_next, q;
    logic signed [SUM_W-1:0]   sat;
    logic [31:0]               res_reg;

    always_comb
    begin
        csum = 17'(coefs.cx) + 17'(coefs.cy) + 17'(coefs.cz);
        coef_c_next = $signed(MCOEF_W'(ONE_Q15) - {1'b0, csum, 1'b0});
        case (tap.tap)
            TAP_CENTER:        coef_sel = coef_c_reg;
            TAP_X_LO, TAP_X_HI: coef_sel = $signed(MCOEF_W'(coefs.cx));
            TAP_Y_LO, TAP_Y_HI: coef_sel = $signed(MCOEF_W'(coefs.cy));
            TAP_Z_LO, TAP_Z_HI: coef_sel = $signed(MCOEF_W'(coefs.cz));
            default:           coef_sel = '0;
        endcase
        // value = hi * 2^16 + lo, lo unsigned
        lo_s = $signed({1'b0, rd_data[15:0]});
        hi_s = HW'(rd_data >>> 16);
        prod_lo_next = coef_sel * lo_s;
        prod_hi_next = coef_sel * hi_s;
        if (m_first_reg)
        begin
            acc_lo_next = ALW'(prod_lo_reg);
            acc_hi_next = AHW'(prod_hi_reg);
        end
        else
        begin
            acc_lo_next = acc_lo_reg + ALW'(prod_lo_reg);
            acc_hi_next = acc_hi_reg + AHW'(prod_hi_reg);
        end
        sum_next = (SUM_W'(acc_hi_reg) <<< 16) + SUM_W'(acc_lo_reg) + HALF;
        q = sum_reg >>> FRAC_SH;
        if (q > OMAX)
            sat = OMAX;
        else if (q < OMIN)
            sat = OMIN;
        else
            sat = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            fin_reg     <= 1'b0;
            f1_reg      <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            m_valid_reg <= tap.valid & ~tap.write;
            fin_reg     <= m_valid_reg & m_last_reg;
            f1_reg      <= fin_reg;
            done_reg    <= f1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_c_reg  <= coef_c_next;
        m_first_reg <= (tap.tap == TAP_CENTER);
        m_last_reg  <= (tap.tap == TAP_Z_HI);
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        if (m_valid_reg)
        begin
            acc_lo_reg <= acc_lo_next;
            acc_hi_reg <= acc_hi_next;
        end
        sum_reg <= sum_next;
        if (f1_reg)
            res_reg <= 32'(sat);
    end

    assign done     = done_reg;
    assign temp_new = res_reg;

endmodule
